// File: sv/tile_chunk_lru_tracker_unit_assert.svh
// Assertion macros for the chunk LRU tracker
`ifndef TILE_CHUNK_LRU_TRACKER_UNIT_ASSERT_SVH
`define TILE_CHUNK_LRU_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TCL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCL_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TCL_ASSERT(label, clk, rst_n, prop, msg)
`define TCL_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: sv/tcl_pkg.sv
package tcl_pkg;
  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_EVICT  = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_FULL    = 3'd2,
    ST_EVICTED = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_FLUSHED = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHUNK_WIDTH   = 2'd0,
    REG_CHUNK_HEIGHT  = 2'd1,
    REG_CHUNKS_ACROSS = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_e;

  // classified command handed from front to back
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] chunk_index;
    logic [31:0] tile_offset;
    logic [15:0] chunk_x;
    logic [15:0] chunk_y;
  } job_t;
endpackage

// File: sv/tcl_front.sv
module tcl_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     command_i,
  input  logic [31:0]    tile_x_i,
  input  logic [31:0]    tile_y_i,
  input  logic [15:0]    chunk_width_i,
  input  logic [15:0]    chunk_height_i,
  input  logic [15:0]    chunks_across_i,
  input  logic           q_full_i,
  output logic           idle_o,
  output logic           job_valid_o,
  output tcl_pkg::job_t  job_o
);
  import tcl_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE, F_DIVX, F_DIVY, F_MULX, F_MULY, F_SUM, F_PUSH
  } fstate_e;

  fstate_e     state_q;
  cmd_e        cmd_q;
  logic [31:0] num_q, quo_q, rem_q, ty_q, tx_q;
  logic [4:0]  cnt_q;
  logic [15:0] cx_q, cy_q;
  logic [31:0] prodx_q, prody_q, ci_q, to_q;
  logic [15:0] xo_q;

  logic [15:0] div_d;
  logic [32:0] trial;
  logic [31:0] rem_sh;

  assign div_d  = (state_q == F_DIVX) ? chunk_width_i : chunk_height_i;
  assign rem_sh = {rem_q[30:0], num_q[31]};
  assign trial  = {1'b0, rem_sh} - {17'd0, div_d};

  assign idle_o      = (state_q == F_IDLE);
  assign job_valid_o = (state_q == F_PUSH);
  assign job_o       = '{cmd: cmd_q, chunk_index: ci_q, tile_offset: to_q,
                         chunk_x: cx_q, chunk_y: cy_q};

  // restoring divider, one quotient bit a cycle; zero divisor yields all ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cmd_q   <= CMD_NONE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: if (start_i) begin
          cmd_q <= cmd_e'(command_i);
          tx_q  <= tile_x_i;
          ty_q  <= tile_y_i;
          ci_q  <= '0;
          to_q  <= '0;
          cx_q  <= '0;
          cy_q  <= '0;
          if (cmd_e'(command_i) == CMD_ACCESS) begin
            num_q   <= tile_x_i;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= F_DIVX;
          end else if (cmd_e'(command_i) != CMD_NONE) begin
            state_q <= F_PUSH;
          end
        end
        F_DIVX, F_DIVY: begin
          if (cnt_q == 5'd31) begin
            // last quotient bit goes straight into the 16-bit result
            cnt_q <= '0;
            if (state_q == F_DIVX) begin
              cx_q    <= {quo_q[14:0], ~trial[32]};
              num_q   <= ty_q;
              rem_q   <= '0;
              state_q <= F_DIVY;
            end else begin
              cy_q    <= {quo_q[14:0], ~trial[32]};
              state_q <= F_MULX;
            end
          end else begin
            cnt_q <= cnt_q + 5'd1;
            num_q <= {num_q[30:0], 1'b0};
            rem_q <= trial[32] ? rem_sh : trial[31:0];
            quo_q <= {quo_q[30:0], ~trial[32]};
          end
        end
        F_MULX: begin
          prodx_q <= {16'd0, cx_q} * {16'd0, chunk_width_i};
          prody_q <= {16'd0, cy_q} * {16'd0, chunk_height_i};
          state_q <= F_MULY;
        end
        F_MULY: begin
          xo_q    <= tx_q[15:0] - prodx_q[15:0];
          to_q    <= {16'd0, ty_q[15:0] - prody_q[15:0]};
          ci_q    <= {16'd0, cy_q} * {16'd0, chunks_across_i};
          state_q <= F_SUM;
        end
        F_SUM: begin
          to_q    <= {16'd0, xo_q} + {16'd0, to_q[15:0]} * {16'd0, chunk_width_i};
          ci_q    <= ci_q + {16'd0, cx_q};
          state_q <= F_PUSH;
        end
        F_PUSH: if (!q_full_i) state_q <= F_IDLE;
        default: state_q <= F_IDLE;
      endcase
    end
  end
endmodule

// File: sv/tcl_queue.sv
module tcl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcl_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tcl_pkg::job_t pop_data_o
);
  import tcl_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && valid_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, pop_i && valid_o};
    end
  end
endmodule

// File: sv/tcl_back.sv
module tcl_back #(
  parameter int unsigned Slots = tcl_pkg::SlotsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  tcl_pkg::job_t job_i,
  output logic          pop_o,
  output logic          idle_o,
  output logic          valid_o,
  output logic [2:0]    status_o,
  output logic [31:0]   chunk_index_o,
  output logic [31:0]   tile_offset_o,
  output logic [15:0]   chunk_x_o,
  output logic [15:0]   chunk_y_o,
  output logic          last_o
);
  import tcl_pkg::*;

  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CntW = $clog2(Slots + 1);

  typedef enum logic [2:0] {B_IDLE, B_SEARCH, B_SHIFT, B_FLUSH} bstate_e;

  bstate_e      state_q;
  job_t         job_q;
  logic [31:0]  list_q [Slots];
  logic [CntW-1:0] count_q, pos_q;
  logic         found_q;

  logic [IdxW-1:0] pos_idx, pos_nxt_idx, cnt_idx;
  assign pos_idx     = pos_q[IdxW-1:0];
  assign pos_nxt_idx = IdxW'(pos_q + CntW'(1));
  assign cnt_idx     = count_q[IdxW-1:0];

  assign pop_o  = (state_q == B_IDLE) && job_valid_i;
  assign idle_o = (state_q == B_IDLE) && !job_valid_i;

  // list entry 0 is least recent; one entry searched or shifted per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      count_q <= '0;
      valid_o <= 1'b0;
      pos_q   <= '0;
      found_q <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: if (job_valid_i) begin
          job_q   <= job_i;
          pos_q   <= '0;
          found_q <= 1'b0;
          unique case (job_i.cmd)
            CMD_ACCESS: begin
              valid_o <= 1'b0;
              state_q <= B_SEARCH;
            end
            CMD_EVICT, CMD_FLUSH: begin
              if (count_q == '0) begin
                valid_o       <= 1'b1;
                status_o      <= ST_EMPTY;
                chunk_index_o <= '0;
                tile_offset_o <= '0;
                chunk_x_o     <= '0;
                chunk_y_o     <= '0;
                last_o        <= 1'b1;
              end else if (job_i.cmd == CMD_EVICT) begin
                valid_o       <= 1'b1;
                status_o      <= ST_EVICTED;
                chunk_index_o <= list_q[0];
                tile_offset_o <= '0;
                chunk_x_o     <= '0;
                chunk_y_o     <= '0;
                last_o        <= 1'b1;
                state_q       <= B_SHIFT;
              end else begin
                valid_o <= 1'b0;
                state_q <= B_FLUSH;
              end
            end
            default: valid_o <= 1'b0;
          endcase
        end else begin
          valid_o <= 1'b0;
        end
        B_SEARCH: begin
          if (pos_q == count_q) begin
            valid_o       <= 1'b1;
            chunk_index_o <= job_q.chunk_index;
            tile_offset_o <= job_q.tile_offset;
            chunk_x_o     <= job_q.chunk_x;
            chunk_y_o     <= job_q.chunk_y;
            last_o        <= 1'b1;
            if (count_q < CntW'(Slots)) begin
              status_o         <= ST_MISS;
              list_q[cnt_idx]  <= job_q.chunk_index;
              count_q          <= count_q + CntW'(1);
            end else begin
              status_o <= ST_FULL;
            end
            state_q <= B_IDLE;
          end else if (list_q[pos_idx] == job_q.chunk_index) begin
            valid_o       <= 1'b1;
            status_o      <= ST_HIT;
            chunk_index_o <= job_q.chunk_index;
            tile_offset_o <= job_q.tile_offset;
            chunk_x_o     <= job_q.chunk_x;
            chunk_y_o     <= job_q.chunk_y;
            last_o        <= 1'b1;
            found_q       <= 1'b1;
            state_q       <= B_SHIFT;
          end else begin
            valid_o <= 1'b0;
            pos_q   <= pos_q + CntW'(1);
          end
        end
        B_SHIFT: begin
          // close gap at pos; a hit reinserts the chunk at the tail
          valid_o <= 1'b0;
          if (pos_q + CntW'(1) >= count_q) begin
            if (found_q) list_q[pos_idx] <= job_q.chunk_index;
            else count_q <= count_q - CntW'(1);
            state_q <= B_IDLE;
          end else begin
            list_q[pos_idx] <= list_q[pos_nxt_idx];
            pos_q <= pos_q + CntW'(1);
          end
        end
        B_FLUSH: begin
          valid_o       <= 1'b1;
          status_o      <= ST_FLUSHED;
          chunk_index_o <= list_q[pos_idx];
          tile_offset_o <= '0;
          chunk_x_o     <= '0;
          chunk_y_o     <= '0;
          last_o        <= (pos_q + CntW'(1) == count_q);
          pos_q         <= pos_q + CntW'(1);
          if (pos_q + CntW'(1) == count_q) begin
            count_q <= '0;
            state_q <= B_IDLE;
          end
        end
        default: begin
          valid_o <= 1'b0;
          state_q <= B_IDLE;
        end
      endcase
    end
  end
endmodule

// File: sv/tile_chunk_lru_tracker_unit.sv
// Access: serial division (one quotient bit a cycle) for chunk x then chunk y, then
//   multiply, sum and handoff; the next command is taken after the access is pushed.
// Access result is strobed once the back end has searched the list (one list entry a cycle).
// Evict/flush: taken while the 2-deep queue has room; flush gives one result a cycle;
//   the receiver cannot stall.
// Reset (async, active low) empties the list and loads 16, 16, 1 into the registers.
module tile_chunk_lru_tracker_unit #(
  parameter int unsigned SLOTS = tcl_pkg::SlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [31:0] tile_x_i,
  input  logic [31:0] tile_y_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [tcl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic [31:0] chunk_index_o,
  output logic [31:0] tile_offset_o,
  output logic [15:0] chunk_x_o,
  output logic [15:0] chunk_y_o,
  output logic        last_o
);
  import tcl_pkg::*;
  `include "tile_chunk_lru_tracker_unit_assert.svh"

  logic [15:0] chunk_width_q, chunk_height_q, chunks_across_q;
  logic        f_idle, b_idle, q_full, f_valid, q_valid, b_pop;
  job_t        f_job, q_job;
  logic        take_cmd, single_res;

  assign cfg_ready_o = 1'b1;
  assign busy = !f_idle;

  assign take_cmd   = start && !busy && (cmd_e'(command_i) != CMD_NONE);
  assign single_res = valid_o && (status_o != ST_FLUSHED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_width_q   <= 16'd16;
      chunk_height_q  <= 16'd16;
      chunks_across_q <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_CHUNK_WIDTH:   chunk_width_q   <= cfg_data_i;
        REG_CHUNK_HEIGHT:  chunk_height_q  <= cfg_data_i;
        REG_CHUNKS_ACROSS: chunks_across_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcl_front u_front (
    .clk_i, .rst_ni, .start_i(start), .command_i, .tile_x_i, .tile_y_i,
    .chunk_width_i(chunk_width_q), .chunk_height_i(chunk_height_q),
    .chunks_across_i(chunks_across_q), .q_full_i(q_full), .idle_o(f_idle),
    .job_valid_o(f_valid), .job_o(f_job)
  );

  tcl_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .push_data_i(f_job), .full_o(q_full),
    .pop_i(b_pop), .valid_o(q_valid), .pop_data_o(q_job)
  );

  tcl_back #(.Slots(SLOTS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(q_valid), .job_i(q_job), .pop_o(b_pop),
    .idle_o(b_idle), .valid_o, .status_o, .chunk_index_o, .tile_offset_o,
    .chunk_x_o, .chunk_y_o, .last_o
  );

  `TCL_ASSERT_NEVER(a_status_range, clk_i, rst_ni, valid_o && status_o > ST_FLUSHED, "bad status")
  `TCL_ASSERT(a_hit_last, clk_i, rst_ni, single_res |-> last_o, "single result not last")
  `TCL_ASSERT(a_busy_on_start, clk_i, rst_ni, take_cmd |=> busy, "start not taken")
  `TCL_ASSERT_NEVER(a_idle_q, clk_i, rst_ni, b_idle && q_valid, "back idle with queued job")
endmodule
